@@ rtl/egcd_pkg.sv @@
// Shared types for the extended Euclid block.
// Control and status structs passed between the sequencer, divider and coefficient lanes.
// No dependencies.
package egcd_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_FIX,
        S_UPD,
        S_DONE
    } t_state;

    // divider commands
    typedef struct packed {
        logic load;     // take new operands
        logic prep;     // latch magnitudes and signs, clear remainder
        logic step;     // one restoring division step
        logic advance;  // c <= d, d <= Euclidean remainder
    } t_div_ctl;

    // divider status toward the coefficient lanes and sequencer
    typedef struct packed {
        logic qbit;      // quotient bit of the current step
        logic rem_zero;  // magnitude remainder is zero
        logic neg_q;     // operand signs differ
        logic adjust;    // negative dividend with nonzero remainder
        logic d_neg;     // divisor negative
    } t_div_sts;

    // coefficient lane commands
    typedef struct packed {
        logic init;  // load starting coefficients
        logic clr;   // clear product accumulator
        logic step;  // accumulate one quotient bit
        logic fix;   // prev -/+ magnitude product
        logic upd;   // finish the update, shift coefficients
    } t_coef_ctl;

endpackage

@@ rtl/egcd_div.sv @@
// Bit-serial restoring divider for the extended Euclid block, one quotient bit per cycle.
// Holds the running dividend/divisor pair and forms the Euclidean remainder.
// Depends on egcd_pkg.
module egcd_div #(
    parameter int WORD_BITS = 32
) (
    input  logic                  i_clk,
    input  egcd_pkg::t_div_ctl    i_ctl,
    input  logic [WORD_BITS-1:0]  i_a,
    input  logic [WORD_BITS-1:0]  i_b,
    output egcd_pkg::t_div_sts    o_sts,
    output logic [WORD_BITS-1:0]  o_d
);
    import egcd_pkg::*;

    logic [WORD_BITS-1:0] r_c;
    logic [WORD_BITS-1:0] r_d;
    logic [WORD_BITS-1:0] r_md;
    logic [WORD_BITS-1:0] r_dvd;
    logic [WORD_BITS-1:0] r_rem;
    logic                 r_cneg;
    logic                 r_dneg;

    logic [WORD_BITS:0]   trial;
    logic                 ge;
    logic [WORD_BITS-1:0] mag_c;
    logic [WORD_BITS-1:0] mag_d;
    logic                 rem_zero;

    assign mag_c    = r_c[WORD_BITS-1] ? (~r_c + 1'b1) : r_c;
    assign mag_d    = r_d[WORD_BITS-1] ? (~r_d + 1'b1) : r_d;
    assign trial    = {r_rem, r_dvd[WORD_BITS-1]};
    assign ge       = trial >= {1'b0, r_md};
    assign rem_zero = (r_rem == '0);

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_c <= i_a;
            r_d <= i_b;
        end else if (i_ctl.advance) begin
            r_c <= r_d;
            r_d <= r_cneg ? (r_md - r_rem) : r_rem;
        end
        if (i_ctl.prep) begin
            r_md   <= mag_d;
            r_dvd  <= mag_c;
            r_rem  <= '0;
            r_cneg <= r_c[WORD_BITS-1];
            r_dneg <= r_d[WORD_BITS-1];
        end else if (i_ctl.step) begin
            // partial remainder stays below the divisor magnitude, so it fits the word
            r_rem <= ge ? WORD_BITS'(trial - {1'b0, r_md}) : trial[WORD_BITS-1:0];
            r_dvd <= {r_dvd[WORD_BITS-2:0], 1'b0};
        end
    end

    assign o_sts.qbit     = ge;
    assign o_sts.rem_zero = rem_zero;
    assign o_sts.neg_q    = r_cneg ^ r_dneg;
    assign o_sts.adjust   = r_cneg & ~rem_zero;
    assign o_sts.d_neg    = r_dneg;
    assign o_d            = r_d;

endmodule

@@ rtl/egcd_coef.sv @@
// One Bezout coefficient lane: accumulates |q|*cur from serial quotient bits (MSB first)
// and forms prev - q*cur, all modulo 2^WORD_BITS.
// Depends on egcd_pkg.
module egcd_coef #(
    parameter int WORD_BITS = 32
) (
    input  logic                  i_clk,
    input  egcd_pkg::t_coef_ctl   i_ctl,
    input  egcd_pkg::t_div_sts    i_sts,
    input  logic                  i_first,  // 1: cur starts at 1, prev at 0
    output logic [WORD_BITS-1:0]  o_coef
);
    import egcd_pkg::*;

    logic [WORD_BITS-1:0] r_cur;
    logic [WORD_BITS-1:0] r_prev;
    logic [WORD_BITS-1:0] r_acc;
    logic [WORD_BITS-1:0] r_tmp;

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_cur  <= {{(WORD_BITS-1){1'b0}}, i_first};
            r_prev <= {{(WORD_BITS-1){1'b0}}, ~i_first};
        end else if (i_ctl.upd) begin
            r_prev <= r_cur;
            // quotient correction of +1 or -1 for a negative dividend with nonzero remainder
            if (i_sts.adjust) begin
                r_cur <= i_sts.d_neg ? (r_tmp - r_cur) : (r_tmp + r_cur);
            end else begin
                r_cur <= r_tmp;
            end
        end
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.step) begin
            r_acc <= {r_acc[WORD_BITS-2:0], 1'b0} + (i_sts.qbit ? r_cur : '0);
        end
        if (i_ctl.fix) begin
            r_tmp <= i_sts.neg_q ? (r_prev + r_acc) : (r_prev - r_acc);
        end
    end

    assign o_coef = r_cur;

endmodule

@@ rtl/egcd_ctrl.sv @@
// Sequencer for the extended Euclid block: load, divide bit by bit, update coefficients,
// repeat until the remainder is zero, then strobe the result; a zero b goes straight to the strobe.
// Depends on egcd_pkg.
module egcd_ctrl #(
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_b_zero,
    input  egcd_pkg::t_div_sts   i_sts,
    output logic                 o_busy,
    output logic                 o_valid,
    output egcd_pkg::t_div_ctl   o_div,
    output egcd_pkg::t_coef_ctl  o_coef
);
    import egcd_pkg::*;

    localparam int CW = $clog2(WORD_BITS);
    localparam logic [CW-1:0] LAST = CW'(WORD_BITS - 1);

    t_state         r_state;
    t_state         n_state;
    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = i_b_zero ? S_DONE : S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_DIV;
                n_cnt   = '0;
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_state = i_sts.rem_zero ? S_DONE : S_UPD;
            end
            S_UPD: begin
                n_state = S_DIV;
                n_cnt   = '0;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy  = (r_state != S_IDLE);
        o_valid = 1'b0;
        o_div   = '0;
        o_coef  = '0;
        unique case (r_state)
            S_IDLE: begin
                o_div.load  = i_start;
                o_coef.init = i_start;
            end
            S_PREP: begin
                o_div.prep  = 1'b1;
                o_coef.clr  = 1'b1;
            end
            S_DIV: begin
                o_div.step  = 1'b1;
                o_coef.step = 1'b1;
            end
            S_FIX: begin
                o_coef.fix    = 1'b1;
                o_div.advance = ~i_sts.rem_zero;
            end
            S_UPD: begin
                // coefficient update overlaps the next division setup
                o_coef.upd = 1'b1;
                o_div.prep = 1'b1;
                o_coef.clr = 1'b1;
            end
            S_DONE: begin
                o_valid = 1'b1;
            end
            default: begin
                o_valid = 1'b0;
            end
        endcase
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("busy not raised after an accepted transaction");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == LAST) |=> (r_state == S_FIX))
        else $error("division did not end after a full word of steps");

    a_valid_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!o_valid && !o_busy))
        else $error("result strobe longer than one cycle");

    a_fix_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIX && !i_sts.rem_zero) |=> (r_state == S_UPD))
        else $error("nonzero remainder did not start another round");

endmodule

@@ rtl/extended_gcd.sv @@
// Extended Euclid top level: divisor and Bezout coefficients of two signed words.
// Instantiates egcd_ctrl, egcd_div and two egcd_coef lanes; depends on egcd_pkg.
//
// A transaction is taken when start is high and busy is low; busy then stays high until
// the result has been shown. The result appears on o_divisor, o_coef_x, o_coef_y and
// o_zero_divisor for exactly one cycle with o_valid high, and cannot be held off, so
// the receiver must capture it in that cycle. Each Euclid round uses one bit-serial
// restoring divider, one quotient bit per cycle, whose bits feed both coefficient lanes
// at once; for 32-bit words a transaction takes at most about 46 rounds. The next
// transaction can be taken in the cycle after the strobe. A zero b gives the flagged
// all-zero result in the cycle after acceptance. All arithmetic wraps modulo 2^WORD_BITS.
module extended_gcd #(
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [WORD_BITS-1:0] i_a,
    input  logic [WORD_BITS-1:0] i_b,
    output logic                 o_valid,
    output logic [WORD_BITS-1:0] o_divisor,
    output logic [WORD_BITS-1:0] o_coef_x,
    output logic [WORD_BITS-1:0] o_coef_y,
    output logic                 o_zero_divisor
);
    import egcd_pkg::*;

    t_div_ctl             div_ctl;
    t_div_sts             div_sts;
    t_coef_ctl            coef_ctl;
    logic [WORD_BITS-1:0] d_val;
    logic [WORD_BITS-1:0] x_val;
    logic [WORD_BITS-1:0] y_val;
    logic                 b_zero;
    logic                 r_zero;

    assign b_zero = (i_b == '0);

    always_ff @(posedge i_clk) begin
        if (div_ctl.load) begin
            r_zero <= b_zero;
        end
    end

    egcd_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_b_zero (b_zero),
        .i_sts    (div_sts),
        .o_busy   (busy),
        .o_valid  (o_valid),
        .o_div    (div_ctl),
        .o_coef   (coef_ctl)
    );

    egcd_div #(.WORD_BITS(WORD_BITS)) u_div (
        .i_clk   (i_clk),
        .i_ctl   (div_ctl),
        .i_a     (i_a),
        .i_b     (i_b),
        .o_sts   (div_sts),
        .o_d     (d_val)
    );

    egcd_coef #(.WORD_BITS(WORD_BITS)) u_coef_x (
        .i_clk   (i_clk),
        .i_ctl   (coef_ctl),
        .i_sts   (div_sts),
        .i_first (1'b0),
        .o_coef  (x_val)
    );

    egcd_coef #(.WORD_BITS(WORD_BITS)) u_coef_y (
        .i_clk   (i_clk),
        .i_ctl   (coef_ctl),
        .i_sts   (div_sts),
        .i_first (1'b1),
        .o_coef  (y_val)
    );

    // zero b forces an all-zero result
    assign o_divisor      = r_zero ? '0 : d_val;
    assign o_coef_x       = r_zero ? '0 : x_val;
    assign o_coef_y       = r_zero ? '0 : y_val;
    assign o_zero_divisor = r_zero;

endmodule

@@ tb/tb_extended_gcd.sv @@
// Self-checking testbench for extended_gcd: divisor and Bezout coefficients of two signed words.
// Directed table of corner operands, then shaped random operands, checked against a local predictor.
// Depends only on the extended_gcd RTL.
module tb_extended_gcd;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = 32;
    localparam int RANDOM_ITEMS = 346;
    localparam int DRAIN_CYCLES = 1600;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [W-1:0] divisor;
        logic [W-1:0] coef_x;
        logic [W-1:0] coef_y;
        logic         zero_divisor;
    } t_gcd_result;

    typedef struct packed {
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic         typed;
        t_gcd_result  want;
    } t_stim_row;

    typedef struct packed {
        logic [W-1:0] a;
        logic [W-1:0] b;
        t_gcd_result  want;
    } t_pending;

    localparam t_gcd_result ZERO_B = '{32'h0, 32'h0, 32'h0, 1'b1};
    localparam t_gcd_result NONE = '0;

    // typed rows: zero b, or b divides a so the first division ends it (x = 0, y = 1, d = b)
    localparam t_stim_row DIRECTED_ROWS [24] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1, ZERO_B},
        '{32'h0000_0005, 32'h0000_0000, 1'b1, ZERO_B},
        '{32'h8000_0000, 32'h0000_0000, 1'b1, ZERO_B},
        '{32'h8000_0000, 32'hffff_ffff, 1'b1, '{32'hffff_ffff, 32'h0, 32'h1, 1'b0}},
        '{32'h0000_0000, 32'h0000_0007, 1'b1, '{32'h0000_0007, 32'h0, 32'h1, 1'b0}},
        '{32'h0000_000c, 32'h0000_0004, 1'b1, '{32'h0000_0004, 32'h0, 32'h1, 1'b0}},
        '{32'h0000_000c, 32'hffff_fffc, 1'b1, '{32'hffff_fffc, 32'h0, 32'h1, 1'b0}},
        '{32'h7fff_ffff, 32'h7fff_ffff, 1'b1, '{32'h7fff_ffff, 32'h0, 32'h1, 1'b0}},
        '{32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h8000_0000, 32'h0, 32'h1, 1'b0}},
        '{32'hffff_ffff, 32'h0000_0001, 1'b1, '{32'h0000_0001, 32'h0, 32'h1, 1'b0}},
        '{32'h0000_0001, 32'hffff_ffff, 1'b1, '{32'hffff_ffff, 32'h0, 32'h1, 1'b0}},
        '{32'hffff_ffff, 32'hffff_ffff, 1'b1, '{32'hffff_ffff, 32'h0, 32'h1, 1'b0}},
        '{32'h0000_0000, 32'hffff_ffff, 1'b1, '{32'hffff_ffff, 32'h0, 32'h1, 1'b0}},
        '{32'h0000_0001, 32'h0000_0001, 1'b1, '{32'h0000_0001, 32'h0, 32'h1, 1'b0}},
        '{32'hffff_fff9, 32'h0000_0003, 1'b0, NONE},
        '{32'h0000_0007, 32'hffff_fffd, 1'b0, NONE},
        '{32'hffff_fff9, 32'hffff_fffd, 1'b0, NONE},
        '{32'h7fff_ffff, 32'h8000_0000, 1'b0, NONE},
        '{32'h8000_0000, 32'h7fff_ffff, 1'b0, NONE},
        '{32'h6d73_e55f, 32'h43a5_3f82, 1'b0, NONE},  // consecutive Fibonacci: longest chain
        '{32'h928c_1aa1, 32'h43a5_3f82, 1'b0, NONE},
        '{32'h6d73_e55f, 32'hbc5a_c07e, 1'b0, NONE},
        '{32'h0000_0003, 32'h0000_0005, 1'b0, NONE},
        '{32'haaaa_aaaa, 32'h5555_5555, 1'b0, NONE}
    };

    localparam logic [W-1:0] EDGE_VALUES [5] = '{
        32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0001
    };

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         start;
    logic         busy;
    logic [W-1:0] i_a;
    logic [W-1:0] i_b;
    logic         o_valid;
    logic [W-1:0] o_divisor;
    logic [W-1:0] o_coef_x;
    logic [W-1:0] o_coef_y;
    logic         o_zero_divisor;

    t_pending pending_results[$];
    bit       sender_idles = 1'b1;
    int       mismatches = 0;
    int       sent_count = 0;
    int       zero_b_count = 0;
    int       longest_chain = 0;

    extended_gcd #(
        .WORD_BITS(W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_a(i_a),
        .i_b(i_b),
        .o_valid(o_valid),
        .o_divisor(o_divisor),
        .o_coef_x(o_coef_x),
        .o_coef_y(o_coef_y),
        .o_zero_divisor(o_zero_divisor)
    );

    always #10 i_clk = ~i_clk;

    // Extended Euclid with Euclidean division (remainder never negative), all mod 2^W.
    function automatic t_gcd_result bezout_of(input logic [W-1:0] a, input logic [W-1:0] b,
                                              output int divisions);
        logic [W-1:0] c, d, x, y, px, py, q, r, t, mc, md, qm, rm;
        t_gcd_result res;
        res = '0;
        divisions = 0;
        if (b == '0) begin
            res.zero_divisor = 1'b1;
            return res;
        end
        c = a;
        d = b;
        x = '0;
        y = 1;
        px = 1;
        py = '0;
        while (1'b1) begin
            divisions++;
            mc = c[W-1] ? -c : c;
            md = d[W-1] ? -d : d;
            qm = mc / md;
            rm = mc % md;
            q = (c[W-1] ^ d[W-1]) ? -qm : qm;
            if (c[W-1] && rm != '0) begin
                // pull the remainder up to non-negative, move the quotient away from zero
                r = md - rm;
                q = d[W-1] ? q + 1 : q - 1;
            end else begin
                r = rm;
            end
            if (r == '0)
                break;
            c = d;
            d = r;
            t = px;
            px = x;
            x = t - q * x;
            t = py;
            py = y;
            y = t - q * y;
        end
        res.divisor = d;
        res.coef_x = x;
        res.coef_y = y;
        return res;
    endfunction

    task automatic send_operands(input logic [W-1:0] a, input logic [W-1:0] b,
                                 input logic typed, input t_gcd_result typed_want);
        t_pending entry;
        int divs;
        while (sender_idles && $urandom_range(0, 99) < 30) begin
            start <= 1'b0;
            i_a <= $urandom;
            i_b <= $urandom;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_a <= a;
        i_b <= b;
        do @(posedge i_clk); while (busy !== 1'b0);
        entry.a = a;
        entry.b = b;
        entry.want = bezout_of(a, b, divs);
        if (typed)
            entry.want = typed_want;
        pending_results.push_back(entry);
        sent_count++;
        if (b == '0)
            zero_b_count++;
        if (divs > longest_chain)
            longest_chain = divs;
    endtask

    task automatic check_field(input string name, input t_pending src,
                               input logic [W-1:0] want, input logic [W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch %s: a=%h b=%h expected %h got %h",
                         name, src.a, src.b, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_pending head;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result with no transaction outstanding: d=%h x=%h y=%h z=%b",
                             o_divisor, o_coef_x, o_coef_y, o_zero_divisor);
            end else begin
                head = pending_results.pop_front();
                check_field("divisor", head, head.want.divisor, o_divisor);
                check_field("coef_x", head, head.want.coef_x, o_coef_x);
                check_field("coef_y", head, head.want.coef_y, o_coef_y);
                check_field("zero_divisor", head, W'(head.want.zero_divisor),
                            W'(o_zero_divisor));
            end
        end
    end

    initial begin
        logic [W-1:0] a_val, b_val, f_hi, f_lo, f_t;
        int mode, fib_n;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_a <= '0;
        i_b <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[i])
            send_operands(DIRECTED_ROWS[i].a, DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].typed,
                          DIRECTED_ROWS[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sender_idles = !(n >= 150 && n < 230);
            if (n == 100) begin
                while (pending_results.size() != 0) begin
                    start <= 1'b0;
                    @(posedge i_clk);
                end
            end
            mode = $urandom_range(0, 99);
            if (mode < 40) begin
                a_val = $urandom;
                b_val = $urandom;
            end else if (mode < 60) begin
                a_val = $urandom_range(0, 2000) - 1000;
                b_val = $urandom_range(0, 2000) - 1000;
            end else if (mode < 75) begin
                // b divides a
                b_val = $urandom_range(1, 50);
                if ($urandom_range(0, 1))
                    b_val = -b_val;
                a_val = b_val * ($urandom_range(0, 40000) - 20000);
            end else if (mode < 85) begin
                // consecutive Fibonacci numbers give the deepest chains
                fib_n = $urandom_range(2, 46);
                f_hi = 1;
                f_lo = 1;
                for (int k = 3; k <= fib_n; k++) begin
                    f_t = f_hi + f_lo;
                    f_lo = f_hi;
                    f_hi = f_t;
                end
                a_val = $urandom_range(0, 1) ? -f_hi : f_hi;
                b_val = $urandom_range(0, 1) ? -f_lo : f_lo;
            end else if (mode < 90) begin
                a_val = $urandom;
                b_val = '0;
            end else if (mode < 95) begin
                a_val = EDGE_VALUES[$urandom_range(0, 4)];
                b_val = EDGE_VALUES[$urandom_range(0, 4)];
            end else begin
                a_val = $urandom;
                b_val = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0001;
            end
            send_operands(a_val, b_val, 1'b0, NONE);
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d transactions (%0d from the corner table), %0d with zero b;",
                 sent_count, $size(DIRECTED_ROWS), zero_b_count);
        $display("longest Euclid chain %0d divisions, %0d mismatches", longest_chain,
                 mismatches);
        if (mismatches == 0)
            $display("tb_extended_gcd passed");
        else
            $display("tb_extended_gcd failed");
        $finish;
    end

    // worst case is roughly 400 transactions, each with a full-length Euclid chain; allow several times that
    initial begin
        #80_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("tb_extended_gcd failed");
        $finish;
    end

endmodule
